@@ rtl/rlepid_pkg.sv @@
// ----------------------------------------------------------------------------
// rlepid_pkg
// Shared constants and types of the run-length palette image decoder.
// ----------------------------------------------------------------------------
package rlepid_pkg;

  localparam int Lanes        = 4;
  localparam int LaneCountInt = (Lanes < 1) ? 1 : ((Lanes > 4) ? 4 : Lanes);
  localparam logic [2:0] LaneCnt = 3'(LaneCountInt);

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhRepeat  = 2'd1;
  localparam logic [1:0] PhLiteral = 2'd2;

  localparam logic [7:0] RepeatMax = 8'h80;
  localparam logic [7:0] CountMask = 8'h7f;

  localparam logic RegDecodeMode = 1'b0;
  localparam logic RegTotalBytes = 1'b1;

  typedef struct packed {
    logic accept;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic more;
    logic last_chunk;
  } dp_status_t;

endpackage

@@ rtl/rlepid_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlepid_ctrl
// Sequencer: takes input beats and steps through the extra results of a run.
// ----------------------------------------------------------------------------
module rlepid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rlepid_pkg::dp_status_t status_i,
  output rlepid_pkg::dp_cmd_t    cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = status_i.slot_free;
        cmd_o.accept = in_valid_i && status_i.slot_free;
        if (cmd_o.accept && status_i.more) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = status_i.slot_free;
        if (cmd_o.emit && status_i.last_chunk) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rlepid_datapath.sv @@
// ----------------------------------------------------------------------------
// rlepid_datapath
// Decoder state, configuration registers, run counter and output register.
// ----------------------------------------------------------------------------
module rlepid_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [23:0]           cfg_data_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_start_i,
  input  rlepid_pkg::dp_cmd_t    cmd_i,
  output rlepid_pkg::dp_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           out_data_o,
  output logic [2:0]            out_count_o,
  output logic                  out_last_o,
  output logic                  out_done_o
);

  logic        mode_q;
  logic [23:0] total_q;
  logic [1:0]  phase_q, phase_n;
  logic [7:0]  run_left_q, run_left_n;
  logic [23:0] bw_q, bw_base;
  logic [7:0]  rep_left_q;
  logic [7:0]  rep_byte_q;

  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [2:0]  out_cnt_q;
  logic        out_last_q, out_done_q;

  logic [24:0] diff_acc;
  logic [23:0] rem;
  logic        complete;
  logic [1:0]  ph_eff;
  logic [7:0]  rl_eff;
  logic [7:0]  n_acc;
  logic [2:0]  k_acc, k_em;
  logic        more_acc, done_acc, done_em, last_em;
  logic [23:0] diff_em;

  function automatic logic [31:0] pack_bytes(input logic [7:0] b, input logic [2:0] cnt);
    logic [31:0] d;
    d = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cnt) d[8*i +: 8] = b;
    end
    return d;
  endfunction

  always_comb begin
    bw_base  = in_start_i ? '0 : bw_q;
    ph_eff   = in_start_i ? rlepid_pkg::PhHeader : phase_q;
    rl_eff   = in_start_i ? '0 : run_left_q;
    diff_acc = {1'b0, total_q} - {1'b0, bw_base};
    rem      = diff_acc[23:0];
    complete = diff_acc[24] || (rem == '0);

    phase_n    = ph_eff;
    run_left_n = rl_eff;
    n_acc      = '0;
    if (!complete) begin
      if (!mode_q) begin
        n_acc = 8'd1;
      end else begin
        unique case (ph_eff)
          rlepid_pkg::PhRepeat: begin
            n_acc      = (rem < {16'b0, rl_eff}) ? rem[7:0] : rl_eff;
            phase_n    = rlepid_pkg::PhHeader;
            run_left_n = '0;
          end
          rlepid_pkg::PhLiteral: begin
            run_left_n = rl_eff - 8'd1;
            if (run_left_n == '0) phase_n = rlepid_pkg::PhHeader;
            n_acc = 8'd1;
          end
          default: begin
            if (in_byte_i <= rlepid_pkg::RepeatMax) begin
              run_left_n = in_byte_i;
              phase_n    = rlepid_pkg::PhRepeat;
            end else begin
              run_left_n = in_byte_i & rlepid_pkg::CountMask;
              phase_n    = rlepid_pkg::PhLiteral;
            end
          end
        endcase
      end
    end

    more_acc = n_acc > {5'b0, rlepid_pkg::LaneCnt};
    k_acc    = more_acc ? rlepid_pkg::LaneCnt : n_acc[2:0];
    done_acc = ({21'b0, k_acc} == rem);

    last_em  = !(rep_left_q > {5'b0, rlepid_pkg::LaneCnt});
    k_em     = last_em ? rep_left_q[2:0] : rlepid_pkg::LaneCnt;
    diff_em  = total_q - bw_q;
    done_em  = ({21'b0, k_em} == diff_em);
  end

  assign status_o.slot_free  = !out_valid_q || out_ready_i;
  assign status_o.more       = more_acc;
  assign status_o.last_chunk = last_em;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      total_q     <= '0;
      phase_q     <= rlepid_pkg::PhHeader;
      run_left_q  <= '0;
      bw_q        <= '0;
      rep_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rlepid_pkg::RegDecodeMode: mode_q  <= cfg_data_i[0];
          rlepid_pkg::RegTotalBytes: total_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        phase_q     <= phase_n;
        run_left_q  <= run_left_n;
        bw_q        <= bw_base + {21'b0, k_acc};
        rep_left_q  <= n_acc - {5'b0, k_acc};
        out_valid_q <= (n_acc != '0);
      end else if (cmd_i.emit) begin
        bw_q        <= bw_q + {21'b0, k_em};
        rep_left_q  <= rep_left_q - {5'b0, k_em};
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rep_byte_q <= in_byte_i;
      if (n_acc != '0) begin
        out_data_q <= pack_bytes(in_byte_i, k_acc);
        out_cnt_q  <= k_acc;
        out_last_q <= !more_acc;
        out_done_q <= done_acc;
      end
    end else if (cmd_i.emit) begin
      out_data_q <= pack_bytes(rep_byte_q, k_em);
      out_cnt_q  <= k_em;
      out_last_q <= last_em;
      out_done_q <= done_em;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

endmodule

@@ rtl/rle_palette_image_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// rle_palette_image_decoder_unit
// PackBits-style run-length decoder producing packed 4-bit pixel bytes.
//
//   port group  dir  beat contents
//   s_axis      in   tdata[7:0] encoded byte, tuser start of image
//   m_axis      out  tdata[31:0] bytes, [34:32] byte count, tlast, tuser done
//   cfg         in   idx 0 decode mode, idx 1 total bytes (write only)
//
// A header byte gives no result and literal and raw bytes give one each; the
// value byte of a repeat run of n bytes gives up to four bytes per result (none
// if n is zero or the image is done), one result at a time through the single
// output register, and input is held off while the run drains. A new input beat
// is taken while the previous result is being handed off; a result left waiting
// holds off the input. Reset is asynchronous active low; all decoder state and
// config return to their defaults (run-length mode, total zero).
// ----------------------------------------------------------------------------
module rle_palette_image_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] start_image
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] out_data, [34:32] out_count
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] image_done
);

  rlepid_pkg::dp_cmd_t    cmd;
  rlepid_pkg::dp_status_t status;
  logic [31:0] out_data;
  logic [2:0]  out_count;

  rlepid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlepid_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b0, out_count, out_data};

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.accept && cmd.emit))
    else $error("accept and emit in the same cycle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_count != 3'd0 && out_count <= rlepid_pkg::LaneCnt))
    else $error("byte count out of range");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("image done on a beat that is not the last of its run");

  a_no_take_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !s_axis_tready)
    else $error("input taken while a run drains");

endmodule
